// ===== hw/rtl/upa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package upa_pkg;

    localparam int MAX_ROW   = 1024;
    localparam int CELL_W    = $clog2(MAX_ROW);
    localparam int SAMPLE_W  = 32;
    localparam int COURANT_W = 16;
    localparam int FRAC_W    = COURANT_W - 1;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = COURANT_W + DIFF_W;
    localparam int DELTA_W   = PROD_W + 1 - FRAC_W;
    localparam int SUM_W     = DELTA_W + 1;

    localparam logic signed [PROD_W:0] ROUND_BIAS = (PROD_W + 1)'(1 << (FRAC_W - 1));
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    // One cell update waiting for the arithmetic pipeline.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  center;
        logic signed [DIFF_W-1:0]    diff;
        logic signed [COURANT_W-1:0] courant;
        logic [CELL_W-1:0]           pos;
        logic                        last_of_row;
    } job_t;

    typedef struct packed {
        logic job_valid;
        logic extra_valid;
        logic row_open;
    } front_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/upa_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface upa_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   sample;
    logic signed [15:0]   courant;
    logic                 row_last;

    modport source (output valid, sample, courant, row_last, input ready);
    modport sink   (input valid, sample, courant, row_last, output ready);
endinterface

interface upa_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   new_sample;
    logic [9:0]           cell_index;
    logic                 row_done;

    modport source (output valid, new_sample, cell_index, row_done, input ready);
    modport sink   (input valid, new_sample, cell_index, row_done, output ready);
endinterface

interface upa_cfg_if;
    logic valid;
    logic ready;
    logic update_sign_mode;

    modport source (output valid, update_sign_mode, input ready);
    modport sink   (input valid, update_sign_mode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/upa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upa_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    upa_in_if.sink                 samples,
    output upa_pkg::job_t          job,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output upa_pkg::front_status_t status
);

    logic                                     row_open_reg, row_open_next;
    logic [upa_pkg::CELL_W-1:0]               count_reg, count_next;
    logic signed [upa_pkg::SAMPLE_W-1:0]      first_reg, first_next;
    logic signed [upa_pkg::SAMPLE_W-1:0]      prev_reg, prev_next;
    logic signed [upa_pkg::COURANT_W-1:0]     courant_reg, courant_next;
    upa_pkg::job_t                            job_reg, job_next;
    upa_pkg::job_t                            extra_reg, extra_next;
    logic                                     job_valid_reg, job_valid_next;
    logic                                     extra_valid_reg, extra_valid_next;

    logic                                     accept;
    logic                                     has0, has1;
    upa_pkg::job_t                            j0, j1;
    logic signed [upa_pkg::DIFF_W-1:0]        s_ext, prev_ext, first_ext;

    // A new word is taken only when the second slot is empty, so a row's last
    // word (two updates) always finds room for both.
    assign samples.ready = !extra_valid_reg && (!job_valid_reg || job_ready);
    assign accept        = samples.valid && samples.ready;

    assign s_ext     = {samples.sample[upa_pkg::SAMPLE_W-1], samples.sample};
    assign prev_ext  = {prev_reg[upa_pkg::SAMPLE_W-1], prev_reg};
    assign first_ext = {first_reg[upa_pkg::SAMPLE_W-1], first_reg};

    always_comb
    begin
        has0 = 1'b0;
        has1 = 1'b0;
        j0   = '0;
        j1   = '0;
        if (!row_open_reg)
        begin
            // A one-cell row updates against itself.
            j0.center      = samples.sample;
            j0.diff        = '0;
            j0.courant     = samples.courant;
            j0.pos         = '0;
            j0.last_of_row = 1'b1;
            has0           = samples.row_last;
        end
        else
        begin
            has0       = 1'b1;
            has1       = samples.row_last;
            j0.courant = courant_reg;
            j1.courant = courant_reg;
            j1.last_of_row = 1'b1;
            if (courant_reg[upa_pkg::COURANT_W-1])
            begin
                j0.center = prev_reg;
                j0.diff   = s_ext - prev_ext;
                j0.pos    = count_reg - upa_pkg::CELL_W'(1);
                j1.center = samples.sample;
                j1.diff   = first_ext - s_ext;
                j1.pos    = count_reg;
            end
            else
            begin
                j0.center = samples.sample;
                j0.diff   = s_ext - prev_ext;
                j0.pos    = count_reg;
                j1.center = first_reg;
                j1.diff   = first_ext - s_ext;
                j1.pos    = '0;
            end
        end
    end

    always_comb
    begin
        row_open_next    = row_open_reg;
        count_next       = count_reg;
        first_next       = first_reg;
        prev_next        = prev_reg;
        courant_next     = courant_reg;
        job_next         = job_reg;
        extra_next       = extra_reg;
        job_valid_next   = job_valid_reg;
        extra_valid_next = extra_valid_reg;

        if (accept)
        begin
            job_next         = j0;
            extra_next       = j1;
            job_valid_next   = has0;
            extra_valid_next = has1;
            prev_next        = samples.sample;
            if (!row_open_reg)
            begin
                courant_next  = samples.courant;
                first_next    = samples.sample;
                row_open_next = !samples.row_last;
                count_next    = samples.row_last ? '0 : upa_pkg::CELL_W'(1);
            end
            else if (samples.row_last)
            begin
                row_open_next = 1'b0;
                count_next    = '0;
            end
            else
            begin
                count_next = count_reg + upa_pkg::CELL_W'(1);
            end
        end
        else if (job_valid_reg && job_ready)
        begin
            job_next         = extra_reg;
            job_valid_next   = extra_valid_reg;
            extra_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_open_reg    <= 1'b0;
            count_reg       <= '0;
            job_valid_reg   <= 1'b0;
            extra_valid_reg <= 1'b0;
        end
        else
        begin
            row_open_reg    <= row_open_next;
            count_reg       <= count_next;
            job_valid_reg   <= job_valid_next;
            extra_valid_reg <= extra_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg   <= first_next;
        prev_reg    <= prev_next;
        courant_reg <= courant_next;
        job_reg     <= job_next;
        extra_reg   <= extra_next;
    end

    assign job                = job_reg;
    assign job_valid          = job_valid_reg;
    assign status.job_valid   = job_valid_reg;
    assign status.extra_valid = extra_valid_reg;
    assign status.row_open    = row_open_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/upa_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upa_calc (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire upa_pkg::job_t job,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire logic          mode,
    upa_out_if.source          results
);

    logic signed [upa_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [upa_pkg::SAMPLE_W-1:0] center_reg;
    logic [upa_pkg::CELL_W-1:0]          cell_reg;
    logic                                last_reg;
    logic                                p_valid_reg, p_valid_next;

    logic signed [upa_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [upa_pkg::CELL_W-1:0]          out_cell_reg;
    logic                                out_done_reg;
    logic                                out_valid_reg, out_valid_next;

    logic                                out_load, p_adv;
    logic signed [upa_pkg::PROD_W:0]     rounded;
    logic signed [upa_pkg::DELTA_W-1:0]  delta;
    logic signed [upa_pkg::SUM_W-1:0]    center_ext, delta_ext, sum;

    assign out_load  = !out_valid_reg || results.ready;
    assign p_adv     = !p_valid_reg || out_load;
    assign job_ready = p_adv;

    assign prod_next = job.courant * job.diff;

    // Round half up, then floor by the Q1.15 scale.
    assign rounded    = {prod_reg[upa_pkg::PROD_W-1], prod_reg} + upa_pkg::ROUND_BIAS;
    assign delta      = rounded[upa_pkg::PROD_W:upa_pkg::FRAC_W];
    assign center_ext = upa_pkg::SUM_W'(center_reg);
    assign delta_ext  = upa_pkg::SUM_W'(delta);
    assign sum        = mode ? center_ext + delta_ext : center_ext - delta_ext;

    always_comb
    begin
        if (sum > upa_pkg::SUM_W'(upa_pkg::SAT_MAX))
            out_sample_next = upa_pkg::SAT_MAX;
        else if (sum < upa_pkg::SUM_W'(upa_pkg::SAT_MIN))
            out_sample_next = upa_pkg::SAT_MIN;
        else
            out_sample_next = sum[upa_pkg::SAMPLE_W-1:0];
    end

    always_comb
    begin
        p_valid_next   = p_valid_reg;
        out_valid_next = out_valid_reg;
        if (p_adv)
            p_valid_next = job_valid;
        if (out_load)
            out_valid_next = p_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            prod_reg   <= prod_next;
            center_reg <= job.center;
            cell_reg   <= job.pos;
            last_reg   <= job.last_of_row;
        end
        if (out_load)
        begin
            out_sample_reg <= out_sample_next;
            out_cell_reg   <= cell_reg;
            out_done_reg   <= last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.new_sample = out_sample_reg;
    assign results.cell_index = out_cell_reg;
    assign results.row_done   = out_done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_upwind_advection_row_top.sv =====
//  channel   direction  payload
//  samples   in         sample, courant, row_last
//  results   out        new_sample, cell_index, row_done
//  cfg       in         update_sign_mode
//
//  One sample word is taken per cycle while results is not stalled; the last word of a row
//  holds the input back, because it yields two results and the result side moves one word a cycle.
//  A sample passes through the row tracker register, the product register and the result register.
//  The single 16 by 33 multiplier in the product stage sets the cycle time.
//  rst_n clears the row state and all valid flags asynchronously; the mode resets to 0.
//  A stall on results backs up through the pipeline stage by stage.
`timescale 1ns / 1ps
`default_nettype none

module periodic_upwind_advection_row_top (
    input  wire logic clk,
    input  wire logic rst_n,
    upa_cfg_if.sink   cfg,
    upa_in_if.sink    samples,
    upa_out_if.source results
);

    logic                  mode_reg;
    upa_pkg::job_t         job;
    logic                  job_valid;
    logic                  job_ready;
    upa_pkg::front_status_t status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg.valid)
            mode_reg <= cfg.update_sign_mode;
    end

    upa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .status    (status)
    );

    upa_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .mode      (mode_reg),
        .results   (results)
    );

`ifndef SYNTHESIS
    a_extra_behind_job: assert property (@(posedge clk) disable iff (!rst_n)
        status.extra_valid |-> status.job_valid)
        else $error("second update pending without a first one");

    a_extra_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        status.extra_valid |-> !samples.ready)
        else $error("sample word taken while a second update is pending");

    a_row_closes: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready && samples.row_last |=> !status.row_open)
        else $error("row still open after its last word");
`endif

endmodule

`default_nettype wire
